// ----- rtl/battery_level_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the battery level tracker
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_TRACKER_ASSERT_SVH
`define BATTERY_LEVEL_TRACKER_ASSERT_SVH

// same-cycle implication
`define BLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/blt_pkg.sv -----
// ----------------------------------------------------------------------------
// blt_pkg
// Shared constants, types and the millivolt threshold table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blt_pkg;

  localparam int NUM_LEVELS = 100;
  localparam int ROM_DEPTH  = 100;
  localparam int LEVEL_W    = 7;
  localparam int ADDR_W     = $clog2(ROM_DEPTH);
  localparam int VBAT_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int DELAY_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEVEL_W-1:0]  LEVEL_FULL = LEVEL_W'(NUM_LEVELS);
  localparam logic [LEVEL_W-1:0]  LEVEL_LAST = LEVEL_W'(NUM_LEVELS - 1);
  localparam logic [ADDR_W-1:0]   ADDR_LAST  = ADDR_W'(ROM_DEPTH - 1);
  localparam logic [DELAY_W-1:0]  DELAY_RESET = DELAY_W'(25);

  localparam logic [STATUS_W-1:0] STATUS_NOT_CHARGING = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TERM_DONE    = 3'd7;

  // word index of each register (paddr[2])
  localparam logic [CFG_ADDR_W-3:0] REG_STARTUP_DELAY = 1'b0;

  // thresholds in mV, 13.000 V at level 0 up to 16.641 V
  localparam logic [VBAT_W-1:0] THRESHOLD_TABLE [ROM_DEPTH] = '{
    16'd13000, 16'd13198, 16'd13238, 16'd13328, 16'd13351,
    16'd13417, 16'd13483, 16'd13513, 16'd13579, 16'd13643,
    16'd13689, 16'd13749, 16'd13814, 16'd13830, 16'd13895,
    16'd13916, 16'd13948, 16'd13985, 16'd14019, 16'd14052,
    16'd14054, 16'd14093, 16'd14150, 16'd14179, 16'd14195,
    16'd14225, 16'd14230, 16'd14265, 16'd14280, 16'd14327,
    16'd14355, 16'd14378, 16'd14385, 16'd14402, 16'd14439,
    16'd14459, 16'd14483, 16'd14514, 16'd14524, 16'd14563,
    16'd14609, 16'd14628, 16'd14660, 16'd14684, 16'd14728,
    16'd14748, 16'd14781, 16'd14814, 16'd14851, 16'd14904,
    16'd14930, 16'd14986, 16'd15038, 16'd15056, 16'd15096,
    16'd15147, 16'd15187, 16'd15237, 16'd15254, 16'd15319,
    16'd15347, 16'd15410, 16'd15431, 16'd15462, 16'd15493,
    16'd15528, 16'd15551, 16'd15562, 16'd15579, 16'd15607,
    16'd15633, 16'd15664, 16'd15713, 16'd15737, 16'd15801,
    16'd15830, 16'd15863, 16'd15901, 16'd15949, 16'd16019,
    16'd16047, 16'd16125, 16'd16146, 16'd16167, 16'd16190,
    16'd16205, 16'd16221, 16'd16236, 16'd16245, 16'd16258,
    16'd16261, 16'd16270, 16'd16284, 16'd16299, 16'd16310,
    16'd16324, 16'd16352, 16'd16358, 16'd16370, 16'd16641
  };

  typedef enum logic [4:0] {
    ST_FILL = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic               wr;
    logic [DELAY_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VBAT_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/blt_in_if.sv -----
// ----------------------------------------------------------------------------
// blt_in_if
// Input beat channel: one voltage sample per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface blt_in_if;
  logic                          valid;
  logic                          ready;
  logic [blt_pkg::VBAT_W-1:0]    vbat_mv;
  logic                          ext_supply;
  logic [blt_pkg::STATUS_W-1:0]  chg_code;

  modport source (output valid, output vbat_mv, output ext_supply,
                  output chg_code, input ready);
  modport sink   (input valid, input vbat_mv, input ext_supply,
                  input chg_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/blt_out_if.sv -----
// ----------------------------------------------------------------------------
// blt_out_if
// Result beat channel: level, valid flag and shutdown request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface blt_out_if;
  logic                          valid;
  logic                          ready;
  logic [blt_pkg::LEVEL_W-1:0]   battery_level;
  logic                          level_valid;
  logic                          low_battery_shutdown;

  modport source (output valid, output battery_level, output level_valid,
                  output low_battery_shutdown, input ready);
  modport sink   (input valid, input battery_level, input level_valid,
                  input low_battery_shutdown, output ready);
endinterface

`default_nettype wire

// ----- rtl/blt_ram.sv -----
// ----------------------------------------------------------------------------
// blt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/blt_cfg.sv -----
// ----------------------------------------------------------------------------
// blt_cfg
// APB register slave holding startup_delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [blt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [blt_pkg::CFG_DATA_W-1:0]     pwdata,
  output      logic [blt_pkg::CFG_DATA_W-1:0]     prdata,
  output      logic                               pready,
  output      blt_pkg::cfg_wr_t                   cfg
);

  logic [blt_pkg::DELAY_W-1:0] startup_delay;
  logic                        hit;

  assign hit    = (paddr[blt_pkg::CFG_ADDR_W-1:2] == blt_pkg::REG_STARTUP_DELAY);
  assign pready = 1'b1;

  assign cfg.wr    = psel && penable && pwrite && hit;
  assign cfg.value = pwdata[blt_pkg::DELAY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_delay <= blt_pkg::DELAY_RESET;
    end else if (cfg.wr) begin
      startup_delay <= cfg.value;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = blt_pkg::CFG_DATA_W'(startup_delay);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/blt_ctrl.sv -----
// ----------------------------------------------------------------------------
// blt_ctrl
// Sequencer: table load, start-up countdown, table search and tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blt_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire blt_pkg::cfg_wr_t              cfg,
  blt_in_if.sink                             in_ch,
  blt_out_if.source                          out_ch,
  output      blt_pkg::ram_req_t             ram_req,
  input  wire logic [blt_pkg::VBAT_W-1:0]    rd_data
);

  localparam int LW = blt_pkg::LEVEL_W;
  localparam int AW = blt_pkg::ADDR_W;

  blt_pkg::state_t               state;
  logic [AW-1:0]                 fill_addr;
  logic [AW-1:0]                 rd_addr;
  logic [LW-1:0]                 idx;
  logic [LW-1:0]                 level;
  logic [blt_pkg::DELAY_W-1:0]   delay_cnt;
  logic [blt_pkg::VBAT_W-1:0]    vbat;
  logic                          vbus;
  logic [blt_pkg::STATUS_W-1:0]  status;
  logic                          search;
  logic                          shutdown;
  logic                          accept;
  logic                          publish;
  logic [LW-1:0]                 track_level;

  function automatic logic [LW-1:0] clamp_full(input logic [LW-1:0] l,
                                               input logic [blt_pkg::STATUS_W-1:0] s);
    clamp_full = (l == blt_pkg::LEVEL_FULL && s != blt_pkg::STATUS_NOT_CHARGING)
                 ? blt_pkg::LEVEL_LAST : l;
  endfunction

  assign in_ch.ready = (state == blt_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign publish     = (state == blt_pkg::ST_DONE) && (!out_ch.valid || out_ch.ready);

  assign ram_req.we    = (state == blt_pkg::ST_FILL);
  assign ram_req.waddr = fill_addr;
  assign ram_req.wdata = blt_pkg::THRESHOLD_TABLE[fill_addr];
  assign ram_req.raddr = rd_addr;

  // one step up (supply) or down (no supply) against the fetched threshold
  always_comb begin
    track_level = level;
    if (vbus) begin
      if (vbat > rd_data) begin
        track_level = level + LW'(1);
      end
    end else if (vbat < rd_data) begin
      track_level = level - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= blt_pkg::ST_FILL;
      fill_addr <= '0;
      delay_cnt <= blt_pkg::DELAY_RESET;
      level     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (publish) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        blt_pkg::ST_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == blt_pkg::ADDR_LAST) begin
            state <= blt_pkg::ST_IDLE;
          end
        end
        blt_pkg::ST_IDLE: begin
          if (accept) begin
            vbat     <= in_ch.vbat_mv;
            vbus     <= in_ch.ext_supply;
            status   <= in_ch.chg_code;
            shutdown <= 1'b0;
            search   <= 1'b0;
            if (delay_cnt == '0) begin
              if (in_ch.chg_code == blt_pkg::STATUS_TERM_DONE) begin
                level <= blt_pkg::LEVEL_FULL;
                state <= blt_pkg::ST_DONE;
              end else if (in_ch.ext_supply) begin
                if (level < blt_pkg::LEVEL_LAST) begin
                  rd_addr <= AW'(level);
                  state   <= blt_pkg::ST_RD;
                end else begin
                  level <= clamp_full(level, in_ch.chg_code);
                  state <= blt_pkg::ST_DONE;
                end
              end else if (level != '0) begin
                rd_addr <= AW'(level - LW'(1));
                state   <= blt_pkg::ST_RD;
              end else begin
                shutdown <= 1'b1;
                state    <= blt_pkg::ST_DONE;
              end
            end else if (delay_cnt == blt_pkg::DELAY_W'(1)) begin
              search  <= 1'b1;
              idx     <= '0;
              rd_addr <= '0;
              state   <= blt_pkg::ST_RD;
            end else begin
              delay_cnt <= delay_cnt - blt_pkg::DELAY_W'(1);
              state     <= blt_pkg::ST_DONE;
            end
          end
        end
        blt_pkg::ST_RD: begin
          // prefetch the next entry so the search compares one per cycle
          if (search && rd_addr != blt_pkg::ADDR_LAST) begin
            rd_addr <= rd_addr + AW'(1);
          end
          state <= blt_pkg::ST_CMP;
        end
        blt_pkg::ST_CMP: begin
          if (search) begin
            if (vbat < rd_data) begin
              level     <= idx;
              delay_cnt <= '0;
              state     <= blt_pkg::ST_DONE;
            end else if (idx == blt_pkg::LEVEL_LAST - LW'(1)) begin
              level     <= blt_pkg::LEVEL_LAST;
              delay_cnt <= '0;
              state     <= blt_pkg::ST_DONE;
            end else begin
              idx <= idx + LW'(1);
              if (rd_addr != blt_pkg::ADDR_LAST) begin
                rd_addr <= rd_addr + AW'(1);
              end
            end
          end else begin
            level <= clamp_full(track_level, status);
            state <= blt_pkg::ST_DONE;
          end
        end
        blt_pkg::ST_DONE: begin
          if (publish) begin
            state <= blt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= blt_pkg::ST_FILL;
        end
      endcase

      // register write reloads the countdown until the level is valid
      if (cfg.wr && delay_cnt != '0) begin
        delay_cnt <= (cfg.value != '0) ? cfg.value : blt_pkg::DELAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_ch.battery_level        <= level;
      out_ch.level_valid          <= (delay_cnt == '0);
      out_ch.low_battery_shutdown <= shutdown;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/battery_level_tracker.sv -----
// ----------------------------------------------------------------------------
// battery_level_tracker
// Battery level in percent steps from a millivolt threshold table.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per measurement tick: vbat_mv, ext_supply and
//   chg_code. out_ch returns exactly one beat per input beat with
//   battery_level, level_valid and low_battery_shutdown.
//   The APB port holds startup_delay at byte address 0 (reset 25); a write
//   while the level is not yet valid restarts the countdown (0 acts as 1).
// Sequencing:
//   Countdown, termination, shutdown and at-the-top ticks go from acceptance
//   to the final state, then to the output register once it is free.
//   Tracking ticks that need a threshold pass first through a table read
//   state (registered RAM read) and a compare state. The one-off initial
//   search compares one table entry per cycle, up to 99 entries. The
//   sequencer returns to idle on the edge that registers the result; the
//   threshold RAM has a single read port and one tick is in flight at a time.
// Reset:
//   rst clears the sequencer and level and reloads the countdown with 25,
//   then the threshold RAM is loaded from the package table, one entry per
//   cycle over all 100 entries, while in_ch.ready is low. APB writes are
//   taken throughout.
// Stall:
//   A result waits in the output register while out_ch.ready is low; the
//   next tick is still accepted and processed, and holds in the final state
//   until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "battery_level_tracker_assert.svh"

module battery_level_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  blt_in_if.sink                               in_ch,
  blt_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [blt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [blt_pkg::CFG_DATA_W-1:0]  pwdata,
  output      logic [blt_pkg::CFG_DATA_W-1:0]  prdata,
  output      logic                            pready
);

  blt_pkg::cfg_wr_t             cfg;
  blt_pkg::ram_req_t            ram_req;
  logic [blt_pkg::VBAT_W-1:0]   rd_data;

  // register slave
  blt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // threshold store, loaded after reset, read once per cycle
  blt_ram #(
    .WIDTH (blt_pkg::VBAT_W),
    .DEPTH (blt_pkg::ROM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // sequencer: table load, countdown, search, tracking, output register
  blt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .ram_req (ram_req),
    .rd_data (rd_data)
  );

  // level never beyond full scale
  `BLT_ASSERT_IMP(a_level_range, out_ch.valid,
                  out_ch.battery_level <= blt_pkg::LEVEL_FULL, "level out of range")
  // shutdown only at an empty, valid level
  `BLT_ASSERT_IMP(a_shutdown_empty, out_ch.valid && out_ch.low_battery_shutdown,
                  out_ch.battery_level == '0 && out_ch.level_valid,
                  "shutdown with non-empty level")
  // table load blocks input straight after reset
  `BLT_ASSERT_IMP(a_fill_blocks, $past(rst), !in_ch.ready, "input taken during table load")
  // one tick in flight at a time
  `BLT_ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready,
                  "second tick taken while busy")

endmodule

`default_nettype wire

// ----- tb/tb_battery_level_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_battery_level_tracker
// Drives measurement ticks into the level tracker and checks every result
// beat against a cycle-free predictor: start-up countdown, the one-off table
// search, tracking up and down the threshold table, termination handling and
// the low-battery shutdown flag. The startup_delay register is written and
// read back between phases. Both channels idle at random, with one long
// hold-off on the result side to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_level_tracker;
  import blt_pkg::*;

  // one measurement tick as offered on in_ch
  typedef struct packed {
    logic [VBAT_W-1:0]   vbat;
    logic                vbus;
    logic [STATUS_W-1:0] status;
  } tick_t;

  // one result beat as seen on out_ch
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               valid;
    logic               shutdown;
  } level_rpt_t;

  // flavour of a run of random ticks
  typedef enum {RUN_CHARGE, RUN_DISCHARGE, RUN_NOISE} run_kind_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  blt_in_if  in_ch ();
  blt_out_if out_ch ();

  battery_level_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ticks waiting to be offered, and the results they are predicted to give
  tick_t      pending_ticks[$];
  level_rpt_t expected_levels[$];

  // predictor state: level register and start-up countdown
  int level_now     = 0;
  int countdown_now = DELAY_RESET;
  int mismatches    = 0;

  // idle percentages per side; hold_off forces a long result-side stall
  int   src_idle_pct   = 32;
  int   snk_idle_pct   = 51;
  logic hold_off       = 1'b0;
  logic random_started = 1'b0;

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // threshold lookup; indexes past the end read the last entry
  function automatic int thr_mv(input int idx);
    return THRESHOLD_TABLE[(idx >= ROM_DEPTH) ? ROM_DEPTH - 1 : idx];
  endfunction

  // advance the level state by one tick and return the result beat
  function automatic level_rpt_t track_level(input tick_t t);
    level_rpt_t r;
    int         i;
    r.shutdown = 1'b0;
    if (countdown_now == 0) begin
      if (t.status == STATUS_TERM_DONE) begin
        level_now = NUM_LEVELS;
      end else begin
        if (t.vbus) begin
          // charging: one step up once the voltage clears this level
          if (level_now < NUM_LEVELS - 1 && t.vbat > thr_mv(level_now))
            level_now++;
        end else if (level_now != 0) begin
          // on battery: one step down below the level underneath
          if (t.vbat < thr_mv(level_now - 1))
            level_now--;
        end else begin
          r.shutdown = 1'b1;
        end
        // full only counts while the charger is idle
        if (level_now == NUM_LEVELS && t.status != STATUS_NOT_CHARGING)
          level_now = NUM_LEVELS - 1;
      end
    end else if (countdown_now == 1) begin
      // one-off search: first threshold above the voltage, else the top
      i = 0;
      while (i < NUM_LEVELS - 1 && !(t.vbat < thr_mv(i)))
        i++;
      level_now     = i;
      countdown_now = 0;
    end else begin
      countdown_now--;
    end
    r.level = level_now[LEVEL_W-1:0];
    r.valid = (countdown_now == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tick driver: offers the head of pending_ticks, holds it until taken.
  // The prediction is made on the edge where the beat is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : tick_driver
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_levels.push_back(track_level(pending_ticks.pop_front()));
      if (in_ch.valid && !in_ch.ready) begin
        // beat still on offer, leave it alone
      end else if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        {in_ch.vbat_mv, in_ch.ext_supply, in_ch.chg_code} <= pending_ticks[0];
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each accepted beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : level_monitor
    level_rpt_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_levels.size() == 0) begin
          if (mismatches < 50)
            $display("%0t: unexpected beat: level=%0d valid=%0b shutdown=%0b", $time,
                     out_ch.battery_level, out_ch.level_valid, out_ch.low_battery_shutdown);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (out_ch.battery_level !== want.level || out_ch.level_valid !== want.valid ||
              out_ch.low_battery_shutdown !== want.shutdown) begin
            if (mismatches < 50)
              $display("%0t: expected level=%0d valid=%0b shutdown=%0b, got level=%0d valid=%0b shutdown=%0b",
                       $time, want.level, want.valid, want.shutdown, out_ch.battery_level,
                       out_ch.level_valid, out_ch.low_battery_shutdown);
            mismatches++;
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // long result-side stall once random traffic is flowing; the driver keeps
  // offering, so the output register and the sequencer fill and in_ch stalls
  initial begin : long_stall
    wait (random_started);
    repeat (60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_tick(input logic [VBAT_W-1:0] vbat, input logic vbus,
                                    input logic [STATUS_W-1:0] status);
    pending_ticks.push_back('{vbat: vbat, vbus: vbus, status: status});
  endfunction

  function automatic tick_t random_tick(input run_kind_t kind);
    tick_t t;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      t.vbat = VBAT_W'($urandom);
    end else if (pick < 3) begin
      // near a threshold edge: equal, one or two below, one or two above
      t.vbat = VBAT_W'(thr_mv($urandom_range(0, ROM_DEPTH - 1)) + $urandom_range(0, 4) - 2);
    end else begin
      case (kind)
        RUN_CHARGE:    t.vbat = VBAT_W'($urandom_range(16642, 20000));
        RUN_DISCHARGE: t.vbat = VBAT_W'($urandom_range(0, 12999));
        default:       t.vbat = VBAT_W'($urandom_range(12900, 16800));
      endcase
    end
    case (kind)
      RUN_CHARGE: begin
        t.vbus   = ($urandom_range(0, 9) != 0);
        pick     = $urandom_range(0, 9);
        t.status = (pick == 0) ? STATUS_TERM_DONE :
                   (pick == 1) ? STATUS_NOT_CHARGING : STATUS_W'($urandom_range(1, 6));
      end
      RUN_DISCHARGE: begin
        t.vbus   = ($urandom_range(0, 9) == 0);
        t.status = ($urandom_range(0, 9) == 0) ? STATUS_W'($urandom_range(0, 7)) :
                   STATUS_NOT_CHARGING;
      end
      default: begin
        t.vbus   = 1'($urandom_range(0, 1));
        t.status = STATUS_W'($urandom_range(0, 7));
      end
    endcase
    return t;
  endfunction

  // runs of charging, discharging and noise; long discharge runs reach level 0
  function automatic void queue_runs(input int n);
    int        left;
    int        pick;
    int        len;
    run_kind_t kind;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 4);
      kind = (pick < 2) ? RUN_CHARGE : (pick < 4) ? RUN_DISCHARGE : RUN_NOISE;
      len  = $urandom_range(10, 120);
      if (len > left)
        len = left;
      repeat (len) begin
        pending_ticks.push_back(random_tick(kind));
        left--;
      end
    end
  endfunction

  // wait until every tick has been taken and every result has come back
  task automatic drain();
    while (pending_ticks.size() != 0 || expected_levels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write of startup_delay, then a read back of the same register
  task automatic set_startup_delay(input logic [DELAY_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STARTUP_DELAY, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register loads on this edge; a pending countdown restarts, 0 as 1
    if (countdown_now != 0)
      countdown_now = (value == 0) ? 1 : value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(value)) begin
      $display("%0t: startup_delay read back expected %0d, got %0d", $time, value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.vbat_mv    = '0;
    in_ch.ext_supply = 1'b0;
    in_ch.chg_code   = STATUS_NOT_CHARGING;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // countdown from the reset value of 25; level stays 0, not valid
    @(negedge clk);
    push_tick(16'h0000, 1'b0, STATUS_NOT_CHARGING);
    push_tick(16'hFFFF, 1'b1, STATUS_TERM_DONE);
    push_tick(VBAT_W'($urandom), 1'b1, STATUS_W'($urandom_range(1, 6)));
    drain();

    // countdown restarted from the top of the range
    set_startup_delay(8'd255);
    @(negedge clk);
    repeat (4) pending_ticks.push_back(random_tick(RUN_NOISE));
    drain();

    // zero acts as one: the next tick runs the table search
    set_startup_delay(8'd0);
    @(negedge clk);
    push_tick(VBAT_W'($urandom_range(12900, 16700)), 1'($urandom_range(0, 1)),
              STATUS_W'($urandom_range(0, 7)));
    // termination done pins the level to full whatever the search gave
    push_tick(16'hFFFF, 1'b1, STATUS_TERM_DONE);
    // full stays full while the charger is idle, no rise past the top
    push_tick(16'hFFFF, 1'b1, STATUS_NOT_CHARGING);
    // charger busy again: full clamps back one step
    push_tick(16'h0000, 1'b1, STATUS_W'(3));
    push_tick(16'hFFFF, 1'b1, STATUS_W'(5));
    // falling edge of the table: equal holds, one below drops
    push_tick(VBAT_W'(thr_mv(98)), 1'b0, STATUS_NOT_CHARGING);
    push_tick(VBAT_W'(thr_mv(98) - 1), 1'b0, STATUS_NOT_CHARGING);
    // rising edge: equal holds, one above climbs
    push_tick(VBAT_W'(thr_mv(98)), 1'b1, STATUS_W'(1));
    push_tick(VBAT_W'(thr_mv(98) + 1), 1'b1, STATUS_W'(1));
    // from full on battery: compared against the last table entry
    push_tick(16'hFFFF, 1'b1, STATUS_TERM_DONE);
    push_tick(16'h0000, 1'b0, STATUS_W'(4));
    push_tick(16'hFFFF, 1'b1, STATUS_TERM_DONE);
    push_tick(VBAT_W'(thr_mv(ROM_DEPTH)), 1'b0, STATUS_NOT_CHARGING);
    push_tick(VBAT_W'(thr_mv(ROM_DEPTH) - 1), 1'b0, STATUS_W'(6));
    push_tick(16'h0000, 1'b0, STATUS_NOT_CHARGING);
    drain();

    // random runs, sender idles less than receiver, with the long stall
    random_started = 1'b1;
    queue_runs(600);
    drain();

    // level is valid now: writes only load the register
    set_startup_delay(8'd1);
    src_idle_pct = 51;
    snk_idle_pct = 32;
    @(negedge clk);
    queue_runs(550);
    drain();

    set_startup_delay(DELAY_W'($urandom_range(2, 254)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    @(negedge clk);
    queue_runs(530);
    drain();
    set_startup_delay(8'd128);

    // let any stray beat show up before the verdict
    repeat (110) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard limit on the run, far beyond the slowest correct run
  initial begin : watchdog
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
